// ===== rtl/lruc_pkg.sv =====
`timescale 1ns / 1ps

package lruc_pkg;

    // Field widths fixed by the stream format
    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 17;
    localparam int SLOT_W  = 6;
    localparam int STAMP_W = 32;

    // Largest object the table records; bigger stores are clipped to this
    localparam logic [SIZE_W-1:0] MAX_OBJ_BYTES = 17'd102400;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_STORE  = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NOP    = 2'd3
    } lruc_req_t;

    // One result as handed from the controller to the output stage
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot_index;
        logic [SIZE_W-1:0] found_size;
    } lruc_result_t;

endpackage

// ===== rtl/lruc_ram.sv =====
`timescale 1ns / 1ps

module lruc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lruc_ctrl.sv =====
`timescale 1ns / 1ps

module lruc_ctrl
    import lruc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64,
    localparam int IDX_W = $clog2(ENTRIES),
    localparam int CNT_W = $clog2(ENTRIES + 1),
    localparam int MEM_W = STAMP_W + SIZE_W + KEY_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request side
    input  logic                req_valid,
    output logic                req_ready,
    input  lruc_req_t           req_type,
    input  logic [KEY_BITS-1:0] req_key,
    input  logic [SIZE_W-1:0]   req_size,
    // entry memory
    output logic                mem_rd_en,
    output logic [IDX_W-1:0]    mem_rd_addr,
    input  logic [MEM_W-1:0]    mem_rd_data,
    output logic                mem_wr_en,
    output logic [IDX_W-1:0]    mem_wr_addr,
    output logic [MEM_W-1:0]    mem_wr_data,
    // result side
    output logic                res_valid,
    input  logic                res_ready,
    output lruc_result_t        res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } lruc_state_t;

    lruc_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [STAMP_W-1:0]  now_reg, now_next;
    lruc_req_t           kind_reg, kind_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic                issue_reg, issue_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    last_idx_reg, last_idx_next;
    logic                dv_reg, dv_next;
    logic [IDX_W-1:0]    dv_idx_reg, dv_idx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0]  best_stamp_reg, best_stamp_next;
    lruc_result_t        res_reg, res_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;

    // Unpacked read data: {stamp, size, key}
    logic [KEY_BITS-1:0] rd_key;
    logic [SIZE_W-1:0]   rd_size;
    logic [STAMP_W-1:0]  rd_stamp;
    logic                take_rd;
    logic [IDX_W-1:0]    sel_idx;

    assign rd_key   = mem_rd_data[KEY_BITS-1:0];
    assign rd_size  = mem_rd_data[KEY_BITS +: SIZE_W];
    assign rd_stamp = mem_rd_data[KEY_BITS + SIZE_W +: STAMP_W];

    // Victim search: first entry, or a strictly older stamp, takes over
    assign take_rd = (dv_idx_reg == '0) || (rd_stamp < best_stamp_reg);
    assign sel_idx = take_rd ? dv_idx_reg : best_idx_reg;

    assign req_ready   = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_RESP);
    assign res         = res_reg;
    assign mem_rd_en   = (state_reg == ST_SCAN) && issue_reg;
    assign mem_rd_addr = rd_idx_reg;
    assign mem_wr_en   = (state_reg == ST_RESP) && res_ready && wr_pend_reg;
    assign mem_wr_addr = wr_idx_reg;
    assign mem_wr_data = {now_reg, size_reg, key_reg};

    // Sequencer: accept, scan entries one per cycle, then write back and report
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        now_next        = now_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        issue_next      = issue_reg;
        rd_idx_next     = rd_idx_reg;
        last_idx_next   = last_idx_reg;
        dv_next         = dv_reg;
        dv_idx_next     = dv_idx_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        res_next        = res_reg;
        wr_pend_next    = wr_pend_reg;
        wr_idx_next     = wr_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    kind_next   = req_type;
                    key_next    = req_key;
                    size_next   = (req_size > MAX_OBJ_BYTES) ? MAX_OBJ_BYTES : req_size;
                    rd_idx_next = '0;
                    dv_next     = 1'b0;
                    res_next    = '0;
                    wr_pend_next = 1'b0;
                    unique case (req_type)
                        REQ_LOOKUP: begin
                            if (fill_reg == '0) begin
                                state_next = ST_RESP;
                            end else begin
                                issue_next    = 1'b1;
                                last_idx_next = IDX_W'(fill_reg - CNT_W'(1));
                                state_next    = ST_SCAN;
                            end
                        end
                        REQ_STORE: begin
                            if (fill_reg == CNT_W'(ENTRIES)) begin
                                issue_next    = 1'b1;
                                last_idx_next = IDX_W'(ENTRIES - 1);
                                state_next    = ST_SCAN;
                            end else begin
                                // free slot: append at the fill point
                                wr_pend_next        = 1'b1;
                                wr_idx_next         = IDX_W'(fill_reg);
                                res_next.slot_index = SLOT_W'(fill_reg);
                                fill_next           = fill_reg + CNT_W'(1);
                                state_next          = ST_RESP;
                            end
                        end
                        REQ_TICK: begin
                            now_next   = now_reg + STAMP_W'(1);
                            state_next = ST_RESP;
                        end
                        REQ_NOP: begin
                            state_next = ST_RESP;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // the compare works on the read issued in the cycle before
                if (issue_reg) begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == last_idx_reg) begin
                        issue_next = 1'b0;
                    end
                end
                dv_next     = issue_reg;
                dv_idx_next = rd_idx_reg;

                if (dv_reg) begin
                    if (kind_reg == REQ_LOOKUP) begin
                        if (rd_key == key_reg) begin
                            // hit: refresh stamp, keep key and size
                            res_next.hit        = 1'b1;
                            res_next.slot_index = SLOT_W'(dv_idx_reg);
                            res_next.found_size = rd_size;
                            size_next           = rd_size;
                            wr_pend_next        = 1'b1;
                            wr_idx_next         = dv_idx_reg;
                            issue_next          = 1'b0;
                            dv_next             = 1'b0;
                            state_next          = ST_RESP;
                        end else if (dv_idx_reg == last_idx_reg) begin
                            issue_next = 1'b0;
                            dv_next    = 1'b0;
                            state_next = ST_RESP;
                        end
                    end else begin
                        if (take_rd) begin
                            best_idx_next   = dv_idx_reg;
                            best_stamp_next = rd_stamp;
                        end
                        if (dv_idx_reg == last_idx_reg) begin
                            res_next.slot_index = SLOT_W'(sel_idx);
                            wr_pend_next        = 1'b1;
                            wr_idx_next         = sel_idx;
                            issue_next          = 1'b0;
                            dv_next             = 1'b0;
                            state_next          = ST_RESP;
                        end
                    end
                end
            end

            ST_RESP: begin
                if (res_ready) begin
                    wr_pend_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            now_reg     <= '0;
            issue_reg   <= 1'b0;
            dv_reg      <= 1'b0;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            now_reg     <= now_next;
            issue_reg   <= issue_next;
            dv_reg      <= dv_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        size_reg       <= size_next;
        rd_idx_reg     <= rd_idx_next;
        last_idx_reg   <= last_idx_next;
        dv_idx_reg     <= dv_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        res_reg        <= res_next;
        wr_idx_reg     <= wr_idx_next;
    end

endmodule

// ===== rtl/lru_object_cache_table.sv =====
`timescale 1ns / 1ps
// Tick, unknown request and store into a free slot go straight from acceptance to the result
// register; a lookup first scans up to fill_count entries and a store into a full table all
// ENTRIES entries, one entry per cycle through the entry RAM's single read port.
// Throughput: one request at a time; the next request is taken once the result has
// moved to the output register. Reset (aresetn low, synchronous) empties the table and
// zeroes the seconds counter at once; no clearing pass is needed.

module lru_object_cache_table
    import lruc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // [63:0] obj_key, [80:64] object_size, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] slot_index, [22:6] found_size, rest zero
    output logic [0:0]  m_tuser    // [0] hit
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int MEM_W = STAMP_W + SIZE_W + KEY_BITS;

    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [MEM_W-1:0]   mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [MEM_W-1:0]   mem_wr_data;
    logic               res_valid;
    logic               res_ready;
    lruc_result_t       res;
    logic               m_valid_reg, m_valid_next;
    lruc_result_t       m_res_reg, m_res_next;

    // Entry store: key, size and stamp side by side
    lruc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lruc_ctrl #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_type    (lruc_req_t'(s_tuser)),
        .req_key     (s_tdata[KEY_BITS-1:0]),
        .req_size    (s_tdata[KEY_W +: SIZE_W]),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register decouples the scan from the downstream stall
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.found_size, m_res_reg.slot_index};
    assign m_tuser  = m_res_reg.hit;

endmodule

// ===== tb/tb_lru_object_cache_table.sv =====
`timescale 1ns / 1ps

module tb_lru_object_cache_table;
    import lruc_pkg::*;

    localparam int TBL_ENTRIES  = 16;
    localparam int TBL_KEY_BITS = 64;
    localparam int RAND_REQS    = 1025;
    localparam int KEY_POOL     = 24;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 120;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_AT     = 500;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (TBL_KEY_BITS >= KEY_W) ? '1 : ((64'd1 << TBL_KEY_BITS) - 64'd1);

    typedef struct {
        lruc_req_t         kind;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        bit                drain;   // hold this request until all replies are back
    } cache_req_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = REQ_NOP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    // Shadow copy of the cache table
    logic [KEY_W-1:0]   tbl_key   [TBL_ENTRIES];
    logic [SIZE_W-1:0]  tbl_size  [TBL_ENTRIES];
    logic [STAMP_W-1:0] tbl_stamp [TBL_ENTRIES];
    int unsigned        tbl_fill = 0;
    logic [STAMP_W-1:0] now_sec  = '0;

    cache_req_t   request_q[$];
    lruc_result_t reply_q[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    int unsigned n_offered = 0;
    int unsigned n_taken   = 0;
    int unsigned err_cnt   = 0;
    int unsigned idle_run  = 0;
    int          tx_gap    = 0;
    int          rx_gap    = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    cache_req_t   drv_req;
    cache_req_t   seen_req;
    lruc_result_t want;

    lru_object_cache_table #(
        .ENTRIES  (TBL_ENTRIES),
        .KEY_BITS (TBL_KEY_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial forever #1 aclk = ~aclk;

    // Apply one request to the shadow table and return the reply it should produce
    function automatic lruc_result_t predict_cache_reply(cache_req_t r);
        lruc_result_t      res;
        logic [KEY_W-1:0]  k;
        logic [SIZE_W-1:0] sz;
        int unsigned       slot;
        bit                found;
        res   = '0;
        k     = r.key & KEY_MASK;
        found = 1'b0;
        case (r.kind)
            REQ_LOOKUP: begin
                // first matching entry wins, stamp refreshed
                for (int i = 0; i < tbl_fill; i++) begin
                    if (!found && tbl_key[i] == k) begin
                        found          = 1'b1;
                        tbl_stamp[i]   = now_sec;
                        res.hit        = 1'b1;
                        res.slot_index = SLOT_W'(i);
                        res.found_size = tbl_size[i];
                    end
                end
            end
            REQ_STORE: begin
                sz = (r.size > MAX_OBJ_BYTES) ? MAX_OBJ_BYTES : r.size;
                if (tbl_fill >= TBL_ENTRIES) begin
                    // oldest stamp is evicted, ties go to the lowest index
                    slot = 0;
                    for (int i = 1; i < TBL_ENTRIES; i++) begin
                        if (tbl_stamp[i] < tbl_stamp[slot]) slot = i;
                    end
                end else begin
                    slot = tbl_fill;
                    tbl_fill++;
                end
                tbl_key[slot]   = k;
                tbl_size[slot]  = sz;
                tbl_stamp[slot] = now_sec;
                res.slot_index  = SLOT_W'(slot);
            end
            REQ_TICK: now_sec = now_sec + 1'b1;
            default: ;
        endcase
        return res;
    endfunction

    function automatic void add_req(lruc_req_t kind, logic [KEY_W-1:0] key,
                                    logic [SIZE_W-1:0] size, bit drain);
        cache_req_t r;
        r.kind  = kind;
        r.key   = key;
        r.size  = size;
        r.drain = drain;
        request_q.push_back(r);
    endfunction

    // No random idling every so often and near the end of the run
    function automatic bit calm_phase(int unsigned n);
        return ((n % 200) >= 150) || (request_q.size() < CALM_TAIL);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_cnt++;
    endtask

    // Request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (n_taken < n_offered) begin
            // offer still outstanding, keep it on the bus
        end else if (tx_gap > 0) begin
            s_tvalid <= 1'b0;
            tx_gap--;
        end else if (request_q.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (request_q[0].drain && reply_q.size() != 0) begin
            s_tvalid <= 1'b0;
        end else if (!calm_phase(n_offered) && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            tx_gap = $urandom_range(0, 5);
        end else begin
            drv_req = request_q.pop_front();
            s_tuser  <= drv_req.kind;
            s_tdata  <= {7'd0, drv_req.size, drv_req.key};
            s_tvalid <= 1'b1;
            n_offered++;
        end
    end

    // Reply side backpressure, with one long hold-off to fill the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && n_taken >= 400) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else if (!calm_phase(n_taken) && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Reply checker, then prediction for the request taken at this edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (reply_q.size() == 0) begin
                report_mismatch($sformatf("reply with nothing pending: hit=%0b slot=%0d size=%0d",
                                          m_tuser[0], m_tdata[5:0], m_tdata[22:6]));
            end else begin
                want = reply_q.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch($sformatf("hit got %0b want %0b", m_tuser[0], want.hit));
                if (m_tdata[5:0] !== want.slot_index)
                    report_mismatch($sformatf("slot_index got %0d want %0d",
                                              m_tdata[5:0], want.slot_index));
                if (m_tdata[22:6] !== want.found_size)
                    report_mismatch($sformatf("found_size got %0d want %0d",
                                              m_tdata[22:6], want.found_size));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            seen_req.kind  = lruc_req_t'(s_tuser);
            seen_req.key   = s_tdata[63:0];
            seen_req.size  = s_tdata[80:64];
            seen_req.drain = 1'b0;
            reply_q.push_back(predict_cache_reply(seen_req));
            n_taken++;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int                pick;
        logic [KEY_W-1:0]  k;
        logic [SIZE_W-1:0] sz;
        bit                drain;

        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

        // Directed: empty miss, size clipping, duplicate keys, tick, unknown kind,
        // then fill the table and evict on equal stamps
        add_req(REQ_LOOKUP, '0, '0, 1'b0);
        add_req(REQ_TICK, '0, '0, 1'b0);
        add_req(REQ_STORE, '0, '0, 1'b0);
        add_req(REQ_STORE, '1, '1, 1'b0);
        add_req(REQ_STORE, '1, MAX_OBJ_BYTES, 1'b0);
        add_req(REQ_LOOKUP, '1, '0, 1'b0);
        add_req(REQ_LOOKUP, '0, '1, 1'b0);
        add_req(REQ_NOP, {$urandom, $urandom}, 17'($urandom), 1'b0);
        add_req(REQ_STORE, 64'hA5A5_5A5A_F00F_0FF0, MAX_OBJ_BYTES + 1'b1, 1'b0);
        add_req(REQ_TICK, '1, '1, 1'b0);
        add_req(REQ_LOOKUP, 64'hA5A5_5A5A_F00F_0FF0, '0, 1'b0);
        add_req(REQ_LOOKUP, {$urandom, $urandom}, '0, 1'b0);
        for (int i = 0; i < 12; i++)
            add_req(REQ_STORE, key_pool[i], 17'($urandom_range(0, MAX_OBJ_BYTES)), 1'b0);
        add_req(REQ_STORE, key_pool[12], 17'd1, 1'b0);

        // Random traffic over a small key pool so hits and evictions are common
        for (int i = 0; i < RAND_REQS; i++) begin
            pick  = $urandom_range(0, 99);
            k     = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(0, KEY_POOL - 1)];
            sz    = ($urandom_range(0, 4) == 0) ? 17'($urandom)
                                                : 17'($urandom_range(0, MAX_OBJ_BYTES));
            drain = (i == DRAIN_AT);
            if (pick < 45)      add_req(REQ_LOOKUP, k, sz, drain);
            else if (pick < 80) add_req(REQ_STORE, k, sz, drain);
            else if (pick < 95) add_req(REQ_TICK, k, sz, drain);
            else                add_req(REQ_NOP, k, sz, drain);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || n_taken != n_offered || reply_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lruc_pkg.sv
rtl/lruc_ram.sv
rtl/lruc_ctrl.sv
rtl/lru_object_cache_table.sv
tb/tb_lru_object_cache_table.sv
